// File: src/ufdiv_pkg.sv
package ufdiv_pkg;

    localparam int QuotBits = 31;
    localparam int MantW = 31;
    localparam int ExpInW = 9;
    localparam int ExpOutW = 10;
    localparam int RemW = 32;
    localparam int BitsPerStage = 4;
    localparam int NumStages = (QuotBits + BitsPerStage - 1) / BitsPerStage;

    localparam logic [2:0] ClsSnan = 3'd0;
    localparam logic [2:0] ClsQnan = 3'd1;
    localparam logic [2:0] ClsZero = 3'd2;
    localparam logic [2:0] ClsNum  = 3'd3;
    localparam logic [2:0] ClsInf  = 3'd4;

    localparam logic [1:0] RegNanClass = 2'd0;
    localparam logic [1:0] RegNanSign  = 2'd1;
    localparam logic [1:0] RegNanMant  = 2'd2;

    localparam logic [6:0] GuardMask = 7'h7F;
    localparam logic [6:0] GuardHalf = 7'h40;

    typedef struct packed {
        logic                      bypass;
        logic [2:0]                cls;
        logic                      sign;
        logic signed [ExpOutW-1:0] exp;
        logic [MantW-1:0]          mant;
        logic [RemW-1:0]           rem;
        logic [MantW-1:0]          dvsr;
    } t_stage;

endpackage

// File: src/unpacked_float_divide.sv
// Unpacked single-precision divider.
// Input request on s_axis: tdata carries dividend class, sign, exp, mant,
// then divisor class, sign, exp, mant (lowest bits first). Result on
// m_axis: tdata carries quotient class, sign, exp, mant.
// The configuration port (APB, pready always high) holds the default NaN:
// nan_class at 0x0, nan_sign at 0x4, nan_mant at 0x8; all reset to 0.
// Special operands are resolved in the first stage and ride along the pipe.
// Finite operands run a restoring divide, up to four quotient bits per stage
// over eight stages, then a rounding stage and an output register.
// Throughput: one request per cycle unless the output stalls; the pipe has no feedback path.
// Stall: when m_axis_tready is low and the output register is full, every
// stage holds and s_axis_tready drops; the pipe advances as one whole, so
// a bubble inside it does not absorb a stall. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties all valid bits and clears the
// configuration registers.
module unpacked_float_divide (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_cls[2:0] a_sign[3] a_exp[12:4] a_mant[43:13] b_cls[46:44] b_sign[47]
    // b_exp[56:48] b_mant[87:57], zero fill to 95
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cls[2:0] sign[3] exp[13:4] mant[44:14], zero fill to 47
    output logic [47:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NS = ufdiv_pkg::NumStages;
    localparam int BPS = ufdiv_pkg::BitsPerStage;
    localparam int MW = ufdiv_pkg::MantW;
    localparam int RW = ufdiv_pkg::RemW;
    localparam int EW = ufdiv_pkg::ExpOutW;

    logic          r_nan_class, r_nan_sign;
    logic [MW-1:0] r_nan_mant;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nan_class <= 1'b0;
            r_nan_sign  <= 1'b0;
            r_nan_mant  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                ufdiv_pkg::RegNanClass: r_nan_class <= pwdata[0];
                ufdiv_pkg::RegNanSign:  r_nan_sign  <= pwdata[0];
                ufdiv_pkg::RegNanMant:  r_nan_mant  <= pwdata[MW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            ufdiv_pkg::RegNanClass: prdata = {31'd0, r_nan_class};
            ufdiv_pkg::RegNanSign:  prdata = {31'd0, r_nan_sign};
            ufdiv_pkg::RegNanMant:  prdata = {1'b0, r_nan_mant};
            default:                prdata = '0;
        endcase
    end

    // pipeline: stage 0 = decode, 1..NS = divide, NS+1 = round, NS+2 = output
    localparam int LastDiv = NS;
    logic                  adv;
    logic [NS+2:0]         r_vld;
    ufdiv_pkg::t_stage     r_st [0:NS];
    ufdiv_pkg::t_stage     n_st [0:NS];
    logic [MW-1:0]         r_q  [1:NS];
    logic [MW-1:0]         n_q  [1:NS];
    logic [47:0]           r_out_data, n_out_data;
    logic [47:0]           r_rnd_data;

    assign adv = !r_vld[NS+2] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_vld[NS+2];
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS+1:0], s_axis_tvalid};
        end
    end

    // decode and special cases
    logic [2:0]           a_cls, b_cls;
    logic                 a_sgn, b_sgn;
    logic signed [8:0]    a_exp, b_exp;
    logic [MW-1:0]        a_man, b_man;
    logic signed [EW-1:0] exp_diff;

    assign a_cls = s_axis_tdata[2:0];
    assign a_sgn = s_axis_tdata[3];
    assign a_exp = s_axis_tdata[12:4];
    assign a_man = s_axis_tdata[43:13];
    assign b_cls = s_axis_tdata[46:44];
    assign b_sgn = s_axis_tdata[47];
    assign b_exp = s_axis_tdata[56:48];
    assign b_man = s_axis_tdata[87:57];
    assign exp_diff = EW'(a_exp) - EW'(b_exp);

    always_comb begin
        n_st[0] = '0;
        n_st[0].sign = a_sgn ^ b_sgn;
        n_st[0].dvsr = b_man;
        if (a_cls == ufdiv_pkg::ClsSnan || a_cls == ufdiv_pkg::ClsQnan) begin
            n_st[0].bypass = 1'b1;
            n_st[0].cls = a_cls;
            n_st[0].sign = a_sgn;
            n_st[0].exp = EW'(a_exp);
            n_st[0].mant = a_man;
        end else if (b_cls == ufdiv_pkg::ClsSnan || b_cls == ufdiv_pkg::ClsQnan) begin
            n_st[0].bypass = 1'b1;
            n_st[0].cls = b_cls;
            n_st[0].sign = b_sgn;
            n_st[0].exp = EW'(b_exp);
            n_st[0].mant = b_man;
        end else if (a_cls == ufdiv_pkg::ClsInf || a_cls == ufdiv_pkg::ClsZero) begin
            n_st[0].bypass = 1'b1;
            if (a_cls == b_cls) begin
                n_st[0].cls = {2'b00, r_nan_class};
                n_st[0].sign = r_nan_sign;
                n_st[0].mant = r_nan_mant;
            end else begin
                n_st[0].cls = a_cls;
                n_st[0].exp = EW'(a_exp);
                n_st[0].mant = a_man;
            end
        end else if (b_cls == ufdiv_pkg::ClsInf) begin
            n_st[0].bypass = 1'b1;
            n_st[0].cls = a_cls;
        end else if (b_cls == ufdiv_pkg::ClsZero) begin
            n_st[0].bypass = 1'b1;
            n_st[0].cls = ufdiv_pkg::ClsInf;
            n_st[0].exp = EW'(a_exp);
            n_st[0].mant = a_man;
        end else begin
            n_st[0].cls = a_cls;
            // pre-normalize so the first quotient bit is the top one
            if (a_man < b_man) begin
                n_st[0].exp = exp_diff - EW'(1);
                n_st[0].rem = {a_man, 1'b0};
            end else begin
                n_st[0].exp = exp_diff;
                n_st[0].rem = {1'b0, a_man};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0] <= n_st[0];
        end
    end

    // divide stages, up to BPS quotient bits each (the last stage takes the rest), MSB first
    for (genvar s = 1; s <= NS; s++) begin : g_div
        always_comb begin
            logic [RW-1:0] rem;
            logic [MW-1:0] q;
            int            pos;
            n_st[s] = r_st[s-1];
            rem = r_st[s-1].rem;
            q = (s == 1) ? '0 : r_q[(s == 1) ? 1 : s-1];
            for (int k = 0; k < BPS; k++) begin
                pos = ufdiv_pkg::QuotBits - 1 - ((s - 1) * BPS + k);
                if (pos >= 0) begin
                    if (rem >= RW'(r_st[s-1].dvsr)) begin
                        q[pos] = 1'b1;
                        rem = rem - RW'(r_st[s-1].dvsr);
                    end
                    rem = {rem[RW-2:0], 1'b0};
                end
            end
            n_st[s].rem = rem;
            n_q[s] = q;
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_st[s] <= n_st[s];
                r_q[s]  <= n_q[s];
            end
        end
    end

    // round to even on the guard bits
    always_comb begin
        logic [MW-1:0] q;
        q = r_q[LastDiv];
        if ((q[6:0] & ufdiv_pkg::GuardMask) == ufdiv_pkg::GuardHalf
                && (q[7] || r_st[LastDiv].rem != '0)) begin
            q = q + MW'(ufdiv_pkg::GuardHalf);
        end
        if (r_st[LastDiv].bypass) begin
            n_out_data = {3'd0, r_st[LastDiv].mant, r_st[LastDiv].exp,
                          r_st[LastDiv].sign, r_st[LastDiv].cls};
        end else begin
            n_out_data = {3'd0, q, r_st[LastDiv].exp,
                          r_st[LastDiv].sign, r_st[LastDiv].cls};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rnd_data <= n_out_data;
            r_out_data <= r_rnd_data;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_pipe_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_vld[1] == $past(r_vld[0]))
        else $error("valid bit lost in pipe");
    a_pipe_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipe moved while stalled");
endmodule

// File: tb/sv/unpacked_float_divide_chk.sv
`timescale 1ns / 100ps

module unpacked_float_divide_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_fire,
    input  logic [95:0] i_req_data,
    input  logic        i_res_fire,
    input  logic [47:0] i_res_data,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_cnt,
    output int          o_pending,
    output int          o_quot_cnt
);

    typedef struct packed {
        logic [2:0]         cls;
        logic               sign;
        logic signed [9:0]  exp;
        logic [30:0]        mant;
    } t_quot;

    logic        nan_cls_q;
    logic        nan_sgn_q;
    logic [30:0] nan_mant_q;
    t_quot       quot_q[$];

    function automatic t_quot divide_unpacked(logic [95:0] d);
        logic [2:0]        acls, bcls;
        logic              asgn, bsgn, sgn;
        logic signed [9:0] aexp, bexp, qexp;
        logic [30:0]       aman, bman, qm;
        logic [31:0]       rem;
        t_quot             res;
        acls = d[2:0];   asgn = d[3];  aexp = 10'(signed'(d[12:4]));  aman = d[43:13];
        bcls = d[46:44]; bsgn = d[47]; bexp = 10'(signed'(d[56:48])); bman = d[87:57];
        sgn = asgn ^ bsgn;
        if (acls < ufdiv_pkg::ClsZero) begin
            res = '{acls, asgn, aexp, aman};
        end else if (bcls < ufdiv_pkg::ClsZero) begin
            res = '{bcls, bsgn, bexp, bman};
        end else if (acls == ufdiv_pkg::ClsInf || acls == ufdiv_pkg::ClsZero) begin
            if (acls == bcls) res = '{{2'b0, nan_cls_q}, nan_sgn_q, 10'sd0, nan_mant_q};
            else res = '{acls, sgn, aexp, aman};
        end else if (bcls == ufdiv_pkg::ClsInf) begin
            res = '{acls, sgn, 10'sd0, 31'd0};
        end else if (bcls == ufdiv_pkg::ClsZero) begin
            res = '{ufdiv_pkg::ClsInf, sgn, aexp, aman};
        end else begin
            qexp = aexp - bexp;
            rem = {1'b0, aman};
            if (rem < {1'b0, bman}) begin
                qexp = qexp - 10'sd1;
                rem = rem << 1;
            end
            qm = '0;
            for (int i = 30; i >= 0; i--) begin
                if (rem >= {1'b0, bman}) begin
                    qm[i] = 1'b1;
                    rem = rem - {1'b0, bman};
                end
                rem = rem << 1;
            end
            // round to even on the guard bits; carry out of bit 30 drops
            if ((qm[6:0] & ufdiv_pkg::GuardMask) == ufdiv_pkg::GuardHalf
                    && (qm[7] || rem != 0))
                qm = qm + 31'h40;
            res = '{acls, sgn, qexp, qm};
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_quot want, got;
        if (!i_rst_n) begin
            nan_cls_q <= 1'b0; nan_sgn_q <= 1'b0; nan_mant_q <= '0;
            o_fail_cnt <= 0; o_quot_cnt <= 0;
            quot_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr[3:2])
                    ufdiv_pkg::RegNanClass: nan_cls_q <= i_cfg_data[0];
                    ufdiv_pkg::RegNanSign:  nan_sgn_q <= i_cfg_data[0];
                    ufdiv_pkg::RegNanMant:  nan_mant_q <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_req_fire) quot_q.push_back(divide_unpacked(i_req_data));
            if (i_res_fire) begin
                // unpack from tdata order (class lowest) into the struct
                got = {i_res_data[2:0], i_res_data[3], i_res_data[13:4], i_res_data[44:14]};
                o_quot_cnt <= o_quot_cnt + 1;
                if (quot_q.size() == 0) begin
                    if (o_fail_cnt < 10) $display("unexpected quotient %h", got);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = quot_q.pop_front();
                    if (got !== want || i_res_data[47:45] !== 3'b0) begin
                        if (o_fail_cnt < 10)
                            $display({"mismatch: exp cls %0d s %0d e %0d m %h, ",
                                      "got cls %0d s %0d e %0d m %h"},
                                want.cls, want.sign, want.exp, want.mant,
                                got.cls, got.sign, got.exp, got.mant);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end

    assign o_pending = quot_q.size();

endmodule

// File: tb/sv/unpacked_float_divide_tb.sv
`timescale 1ns / 100ps

module unpacked_float_divide_tb;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    // a_cls a_sign a_exp a_mant b_cls b_sign b_exp b_mant, zero fill
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    // cls sign exp mant, zero fill
    logic [47:0] m_axis_tdata;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_cnt, pending, quot_cnt, idle_cyc, req_cnt;

    unpacked_float_divide i_dut (.*);

    unpacked_float_divide_chk i_chk (
        .i_clk, .i_rst_n,
        .i_req_fire(s_axis_tvalid && s_axis_tready), .i_req_data(s_axis_tdata),
        .i_res_fire(m_axis_tvalid && m_axis_tready), .i_res_data(m_axis_tdata),
        .i_cfg_we(psel && penable && pwrite && pready), .i_cfg_addr(paddr),
        .i_cfg_data(pwdata), .o_fail_cnt(fail_cnt), .o_pending(pending),
        .o_quot_cnt(quot_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: any handshake resets it
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc > 2000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stalls at random, with calm stretches
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_div(logic [2:0] ac, logic as, logic [8:0] ae, logic [30:0] am,
                            logic [2:0] bc, logic bs, logic [8:0] be, logic [30:0] bm);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {8'd0, bm, be, bs, bc, am, ae, as, ac};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        req_cnt++;
    endtask

    function automatic logic [2:0] pick_cls();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return ufdiv_pkg::ClsNum;
        if (r == 19) return 3'($urandom_range(5, 7));
        return 3'($urandom_range(0, 4));
    endfunction

    function automatic logic [30:0] pick_mant();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 31'($urandom);
        if (r == 1) return 31'($urandom) & 31'h7FFFFF80;
        return {1'b1, 30'($urandom)};
    endfunction

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0] cl[5];
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_cnt = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cl = '{ufdiv_pkg::ClsSnan, ufdiv_pkg::ClsQnan, ufdiv_pkg::ClsZero,
               ufdiv_pkg::ClsNum, ufdiv_pkg::ClsInf};
        // every class pair, then edge operands
        foreach (cl[i]) foreach (cl[j])
            send_div(cl[i], 1'b1, 9'h100, 31'h7FFFFFFF, cl[j], 1'b0, 9'h0FF, 31'h40000000);
        send_div(ufdiv_pkg::ClsNum, 1'b0, 9'h0FF, 31'h40000000,
                 ufdiv_pkg::ClsNum, 1'b1, 9'h100, 31'h7FFFFFFF);
        send_div(ufdiv_pkg::ClsNum, 1'b1, 9'h100, 31'h7FFFFFFF,
                 ufdiv_pkg::ClsNum, 1'b1, 9'h0FF, 31'h0);
        send_div(3'd7, 1'b0, 9'h001, 31'h40000040, 3'd6, 1'b0, 9'h0, 31'h40000000);
        send_div(ufdiv_pkg::ClsNum, 1'b0, 9'h0, 31'h400000C0,
                 ufdiv_pkg::ClsNum, 1'b0, 9'h0, 31'h40000000);
        send_div(ufdiv_pkg::ClsNum, 1'b0, 9'h0, 31'h7FFFFFFF,
                 ufdiv_pkg::ClsNum, 1'b0, 9'h0, 31'h1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(ufdiv_pkg::RegNanClass, 32'(ph & 1));
            cfg_write(ufdiv_pkg::RegNanSign, 32'(ph >> 1));
            cfg_write(ufdiv_pkg::RegNanMant,
                      ph == 0 ? 32'h7FFFFFFF : ph == 1 ? 32'h0 : $urandom);
            repeat (330) begin
                send_div(pick_cls(), 1'($urandom), 9'($urandom), pick_mant(),
                         pick_cls(), 1'($urandom), 9'($urandom), pick_mant());
            end
            drain();
        end

        $display("sent %0d divide requests over four default-NaN settings", req_cnt);
        $display("checked %0d quotients", quot_cnt);
        if (fail_cnt == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: unpacked_float_divide.f
src/ufdiv_pkg.sv
src/unpacked_float_divide.sv
tb/sv/unpacked_float_divide_chk.sv
tb/sv/unpacked_float_divide_tb.sv
